FILE: rtl/core/hrlp_pkg.sv
package hrlp_pkg;

  localparam int unsigned ARG_W       = 7;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_QMARK = 8'h3f;

  typedef enum logic [2:0] {
    K_URI      = 3'd0,
    K_NAME     = 3'd1,
    K_VALBEGIN = 3'd2,
    K_VAL      = 3'd3,
    K_NEXT     = 3'd4,
    K_DONE     = 3'd5,
    K_BROKEN   = 3'd6,
    K_TOOMANY  = 3'd7
  } kind_t;

  typedef enum logic [4:0] {
    PH_METHOD  = 5'b00001,
    PH_COLLECT = 5'b00010,
    PH_HEX1    = 5'b00100,
    PH_HEX2    = 5'b01000,
    PH_OVER    = 5'b10000
  } phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [ARG_W-1:0] arg_index;
    logic             truncated;
  } result_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // {valid, nibble}; valid low for anything that is not a hex digit
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/hrlp_if.sv
interface hrlp_req_if import hrlp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] byte_req;

  modport source (output valid, output start_req, output byte_req, input ready);
  modport sink (input valid, input start_req, input byte_req, output ready);
endinterface

interface hrlp_res_if import hrlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       data;
  logic [ARG_W-1:0] arg_index;
  logic             truncated;

  modport source (output valid, output kind, output data, output arg_index,
                  output truncated, input ready);
  modport sink (input valid, input kind, input data, input arg_index,
                input truncated, output ready);
endinterface

FILE: rtl/core/hrlp_front.sv
module hrlp_front import hrlp_pkg::*; #(
  parameter int unsigned URI_BYTES   = 256,
  parameter int unsigned QUERY_BYTES = 256,
  parameter int unsigned MAX_ARGS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  hrlp_req_if.sink  req,
  input  q_status_t q_status,
  output logic      push,
  output result_t   push_data
);

  localparam int unsigned UW = $clog2(URI_BYTES);
  localparam int unsigned QW = $clog2(QUERY_BYTES);

  phase_t           phase, phase_next, phase_e;
  logic             in_query, in_query_next, in_query_e;
  logic             in_value, in_value_next, in_value_e;
  logic [3:0]       hex_high, hex_high_next, hex_high_e;
  logic [UW-1:0]    uri_used, uri_used_next, uri_used_e;
  logic [QW-1:0]    query_used, query_used_next, query_used_e;
  logic [ARG_W-1:0] arg_total, arg_total_next, arg_total_e;
  logic             arg_first_pending, arg_first_pending_next, arg_first_pending_e;
  logic             name_nonempty, name_nonempty_next, name_nonempty_e;

  logic             accept;
  logic             has_result;
  result_t          res;
  logic [7:0]       c;
  logic [4:0]       hx;
  logic             take_en;
  logic             take_lit;
  logic [7:0]       take_c;
  logic [ARG_W-1:0] total;

  assign req.ready = !q_status.full;
  assign accept    = req.valid && req.ready;
  assign c         = req.byte_req;
  assign hx        = hex_decode(c);

  // start of a line restarts from reset state before the byte is taken
  always_comb begin
    if (req.start_req) begin
      phase_e             = PH_METHOD;
      in_query_e          = 1'b0;
      in_value_e          = 1'b0;
      hex_high_e          = 4'h0;
      uri_used_e          = '0;
      query_used_e        = '0;
      arg_total_e         = '0;
      arg_first_pending_e = 1'b1;
      name_nonempty_e     = 1'b0;
    end else begin
      phase_e             = phase;
      in_query_e          = in_query;
      in_value_e          = in_value;
      hex_high_e          = hex_high;
      uri_used_e          = uri_used;
      query_used_e        = query_used;
      arg_total_e         = arg_total;
      arg_first_pending_e = arg_first_pending;
      name_nonempty_e     = name_nonempty;
    end
  end

  always_comb begin
    phase_next             = phase_e;
    in_query_next          = in_query_e;
    in_value_next          = in_value_e;
    hex_high_next          = hex_high_e;
    uri_used_next          = uri_used_e;
    query_used_next        = query_used_e;
    arg_total_next         = arg_total_e;
    arg_first_pending_next = arg_first_pending_e;
    name_nonempty_next     = name_nonempty_e;
    has_result             = 1'b0;
    res.kind               = K_DONE;
    res.data               = 8'h00;
    res.arg_index          = arg_total_e;
    res.truncated          = 1'b0;
    take_en                = 1'b0;
    take_lit               = 1'b0;
    take_c                 = c;
    total                  = arg_total_e + ARG_W'(name_nonempty_e);

    case (phase_e)
      PH_METHOD: begin
        if (c == CH_SPACE) begin
          phase_next = PH_COLLECT;
        end else if (c == CH_NUL) begin
          phase_next = PH_OVER;
          has_result = 1'b1;
        end
      end
      PH_COLLECT: begin
        if (uri_used_e >= UW'(URI_BYTES - 1) || query_used_e >= QW'(QUERY_BYTES - 1)) begin
          phase_next    = PH_OVER;
          has_result    = 1'b1;
          res.truncated = 1'b1;
        end else if (c == CH_SPACE || c == CH_NUL) begin
          arg_total_next = total;
          phase_next     = PH_OVER;
          has_result     = 1'b1;
          res.arg_index  = total;
          res.kind       = (total >= ARG_W'(MAX_ARGS)) ? K_TOOMANY : K_DONE;
        end else if (c == CH_QMARK && !in_query_e) begin
          in_query_next = 1'b1;
        end else if (c == CH_PCT) begin
          phase_next = PH_HEX1;
        end else begin
          take_en  = 1'b1;
          take_lit = 1'b1;
        end
      end
      PH_HEX1: begin
        if (!hx[4]) begin
          phase_next = PH_OVER;
          has_result = 1'b1;
          res.kind   = K_BROKEN;
        end else begin
          hex_high_next = hx[3:0];
          phase_next    = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hx[4]) begin
          phase_next = PH_OVER;
          has_result = 1'b1;
          res.kind   = K_BROKEN;
        end else begin
          phase_next = PH_COLLECT;
          take_en    = 1'b1;
          take_c     = {hex_high_e, hx[3:0]};
        end
      end
      default: begin
      end
    endcase

    // path or query data byte
    if (take_en) begin
      has_result = 1'b1;
      if (!in_query_e) begin
        uri_used_next = uri_used_e + UW'(1);
        res.kind      = K_URI;
        res.data      = take_c;
      end else begin
        query_used_next = query_used_e + QW'(1);
        if (take_lit && take_c == CH_AMP) begin
          arg_total_next         = arg_total_e + ARG_W'(1);
          in_value_next          = 1'b0;
          arg_first_pending_next = 1'b1;
          name_nonempty_next     = 1'b0;
          res.arg_index          = arg_total_e + ARG_W'(1);
          if (arg_total_e + ARG_W'(1) >= ARG_W'(MAX_ARGS)) begin
            phase_next = PH_OVER;
            res.kind   = K_TOOMANY;
          end else begin
            res.kind = K_NEXT;
          end
        end else if (take_lit && take_c == CH_EQ) begin
          if (arg_first_pending_e) begin
            arg_first_pending_next = 1'b0;
            name_nonempty_next     = 1'b0;
          end
          in_value_next = 1'b1;
          res.kind      = K_VALBEGIN;
          res.data      = CH_EQ;
        end else if (in_value_e) begin
          res.kind = K_VAL;
          res.data = take_c;
        end else begin
          if (arg_first_pending_e) begin
            arg_first_pending_next = 1'b0;
            name_nonempty_next     = (take_c != CH_NUL);
          end
          res.kind = K_NAME;
          res.data = take_c;
        end
      end
    end
  end

  assign push      = accept && has_result;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_METHOD;
      in_query          <= 1'b0;
      in_value          <= 1'b0;
      hex_high          <= 4'h0;
      uri_used          <= '0;
      query_used        <= '0;
      arg_total         <= '0;
      arg_first_pending <= 1'b1;
      name_nonempty     <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      in_query          <= in_query_next;
      in_value          <= in_value_next;
      hex_high          <= hex_high_next;
      uri_used          <= uri_used_next;
      query_used        <= query_used_next;
      arg_total         <= arg_total_next;
      arg_first_pending <= arg_first_pending_next;
      name_nonempty     <= name_nonempty_next;
    end
  end

endmodule

FILE: rtl/core/hrlp_queue.sv
module hrlp_queue import hrlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  result_t   push_data,
  input  logic      pop,
  output result_t   pop_data,
  output q_status_t q_status
);

  result_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign q_status.count = count;
  assign pop_data       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/hrlp_back.sv
module hrlp_back import hrlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  result_t    pop_data,
  output logic       pop,
  hrlp_res_if.source res
);

  logic    out_valid;
  result_t out_reg;

  // refill the output register whenever it is empty or being drained
  assign pop = !q_status.empty && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= pop_data;
    end
  end

  assign res.valid     = out_valid;
  assign res.kind      = out_reg.kind;
  assign res.data      = out_reg.data;
  assign res.arg_index = out_reg.arg_index;
  assign res.truncated = out_reg.truncated;

endmodule

FILE: rtl/core/http_request_line_parser.sv
// Channel | Dir | Handshake   | Payload
// --------+-----+-------------+------------------------------------------
// req     | in  | valid/ready | start_req, byte_req
// res     | out | valid/ready | kind, data, arg_index, truncated
//
// Takes one byte per clock while the queue is not full; the parse state machine in the front end updates
// in the same cycle the byte transaction is accepted.
// A result is written into the four-entry queue at the edge that accepts its byte,
// then moves on to the output register once that register is empty or being drained.
// Synchronous reset clears the parse state, queue pointers and output valid;
// no clearing pass is needed, the block is ready the cycle after reset.
// Output stalls fill the queue; req.ready drops only while the queue is full.
module http_request_line_parser import hrlp_pkg::*; #(
  parameter int unsigned URI_BYTES   = 256,
  parameter int unsigned QUERY_BYTES = 256,
  parameter int unsigned MAX_ARGS    = 16
) (
  input  logic       clk,
  input  logic       rst,
  hrlp_req_if.sink   req,
  hrlp_res_if.source res
);

  logic      push;
  logic      pop;
  result_t   push_data;
  result_t   pop_data;
  q_status_t q_status;

  // Front end: classify each byte, advance the parse state, emit a result
  hrlp_front #(
    .URI_BYTES   (URI_BYTES),
    .QUERY_BYTES (QUERY_BYTES),
    .MAX_ARGS    (MAX_ARGS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Short queue decoupling the parser from the output side
  hrlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  // Back end: hold each result in the output register until taken
  hrlp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_data (pop_data),
    .pop      (pop),
    .res      (res)
  );

`ifndef ASSERT_OFF
  // Queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count over depth");

  // A line that starts with a zero byte always ends with a result
  a_empty_line_done: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.start_req && req.byte_req == CH_NUL) |-> push)
    else $error("empty line gave no result");

  // A non-empty queue with a free output register is drained next edge
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && !res.valid) |=> res.valid)
    else $error("queued result not moved to output");
`endif

endmodule

FILE: tb/sv/hrlp_result_checker.sv
`timescale 1ns / 1ps
module hrlp_result_checker import hrlp_pkg::*; #(
  parameter int unsigned URI_BYTES   = 256,
  parameter int unsigned QUERY_BYTES = 256,
  parameter int unsigned MAX_ARGS    = 16
) (
  input  logic clk,
  input  logic rst,
  hrlp_req_if  req,
  hrlp_res_if  res,
  output int   mismatches,
  output int   pending
);

  result_t     expected_results[$];
  result_t     want;
  int          fail_count;

  phase_t      ph;
  bit          in_query;
  bit          in_value;
  bit          first_pending;
  bit          name_nonempty;
  logic [3:0]  hex_hi;
  int unsigned uri_used;
  int unsigned query_used;
  int unsigned arg_count;

  function automatic void clear_parse();
    ph            = PH_METHOD;
    in_query      = 1'b0;
    in_value      = 1'b0;
    hex_hi        = 4'd0;
    uri_used      = 0;
    query_used    = 0;
    arg_count     = 0;
    first_pending = 1'b1;
    name_nonempty = 1'b0;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] d, logic t);
    result_t r;
    r.kind      = k;
    r.data      = d;
    r.arg_index = ARG_W'(arg_count);
    r.truncated = t;
    expected_results.push_back(r);
  endfunction

  // {ok, value}: digits carry their value in the low nibble, letters in the low nibble plus 9
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (lc >= 8'h61 && lc <= 8'h66) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void take(logic [7:0] c, bit literal);
    if (!in_query) begin
      uri_used++;
      emit(K_URI, c, 1'b0);
      return;
    end
    query_used++;
    if (literal && c == CH_AMP) begin
      arg_count++;
      in_value      = 1'b0;
      first_pending = 1'b1;
      name_nonempty = 1'b0;
      if (arg_count >= MAX_ARGS) begin
        ph = PH_OVER;
        emit(K_TOOMANY, 8'd0, 1'b0);
      end else begin
        emit(K_NEXT, 8'd0, 1'b0);
      end
      return;
    end
    if (literal && c == CH_EQ) begin
      if (first_pending) begin
        first_pending = 1'b0;
        name_nonempty = 1'b0;
      end
      in_value = 1'b1;
      emit(K_VALBEGIN, CH_EQ, 1'b0);
      return;
    end
    if (in_value) begin
      emit(K_VAL, c, 1'b0);
      return;
    end
    if (first_pending) begin
      first_pending = 1'b0;
      name_nonempty = (c != CH_NUL);
    end
    emit(K_NAME, c, 1'b0);
  endfunction

  function automatic void parse_byte(bit st, logic [7:0] c);
    logic [4:0] h;
    h = nibble_of(c);
    if (st) clear_parse();
    case (ph)
      PH_METHOD: begin
        if (c == CH_SPACE) begin
          ph = PH_COLLECT;
        end else if (c == CH_NUL) begin
          ph = PH_OVER;
          emit(K_DONE, 8'd0, 1'b0);
        end
      end
      PH_COLLECT: begin
        if (uri_used >= URI_BYTES - 1 || query_used >= QUERY_BYTES - 1) begin
          ph = PH_OVER;
          emit(K_DONE, 8'd0, 1'b1);
        end else if (c == CH_SPACE || c == CH_NUL) begin
          if (name_nonempty) arg_count++;
          ph = PH_OVER;
          emit((arg_count >= MAX_ARGS) ? K_TOOMANY : K_DONE, 8'd0, 1'b0);
        end else if (c == CH_QMARK && !in_query) begin
          in_query = 1'b1;
        end else if (c == CH_PCT) begin
          ph = PH_HEX1;
        end else begin
          take(c, 1'b1);
        end
      end
      PH_HEX1: begin
        if (!h[4]) begin
          ph = PH_OVER;
          emit(K_BROKEN, 8'd0, 1'b0);
        end else begin
          hex_hi = h[3:0];
          ph     = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!h[4]) begin
          ph = PH_OVER;
          emit(K_BROKEN, 8'd0, 1'b0);
        end else begin
          ph = PH_COLLECT;
          take({hex_hi, h[3:0]}, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void flag(string what, bit have_want, result_t w);
    fail_count++;
    if (fail_count <= 10) begin
      if (have_want)
        $display("mismatch at %0t: %s, expected kind=%0d data=%02h idx=%0d trunc=%0b, got kind=%0d data=%02h idx=%0d trunc=%0b",
                 $realtime, what, w.kind, w.data, w.arg_index, w.truncated,
                 res.kind, res.data, res.arg_index, res.truncated);
      else
        $display("mismatch at %0t: %s, got kind=%0d data=%02h idx=%0d trunc=%0b",
                 $realtime, what, res.kind, res.data, res.arg_index, res.truncated);
    end
  endfunction

  initial clear_parse();

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_results.delete();
    end else begin
      // compare before predicting: a result never belongs to the byte of the same edge
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          flag("unexpected result", 1'b0, want);
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind || res.data !== want.data ||
              res.arg_index !== want.arg_index || res.truncated !== want.truncated)
            flag("field mismatch", 1'b1, want);
        end
      end
      if (req.valid && req.ready) parse_byte(req.start_req, req.byte_req);
    end
    mismatches <= fail_count;
    pending    <= expected_results.size();
  end

endmodule

FILE: tb/sv/tb_http_request_line_parser.sv
`timescale 1ns / 1ps
module tb_http_request_line_parser;
  import hrlp_pkg::*;

  localparam int unsigned URI_BYTES       = 256;
  localparam int unsigned QUERY_BYTES     = 256;
  localparam int unsigned MAX_ARGS        = 16;
  localparam int unsigned ITEMS_PER_PHASE = 100;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int unsigned QUIET_LIMIT     = 4000;
  // Leave generous slack after the last result.
  localparam int unsigned DRAIN_CYCLES    = 16;

  logic        clk;
  logic        rst;
  int          mismatches;
  int          pending;
  int unsigned quiet_cycles;
  int unsigned sent;
  int unsigned idle_pct;
  int unsigned stall_pct;
  logic [7:0]  line_q[$];

  // Idle percentages per phase: free running, sender idle, receiver stall, both.
  int unsigned idle_tab[4]  = '{0, 79, 0, 36};
  int unsigned stall_tab[4] = '{0, 0, 79, 36};

  hrlp_req_if req();
  hrlp_res_if res();

  http_request_line_parser #(
    .URI_BYTES  (URI_BYTES),
    .QUERY_BYTES(QUERY_BYTES),
    .MAX_ARGS   (MAX_ARGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  hrlp_result_checker #(
    .URI_BYTES  (URI_BYTES),
    .QUERY_BYTES(QUERY_BYTES),
    .MAX_ARGS   (MAX_ARGS)
  ) result_chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: decide ready for the next edge at each falling edge.
  always @(negedge clk) begin
    res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hang detector: count cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drive one byte transaction. Entered and left at a falling edge; the random
  // idle loop drops valid for whole cycles before the byte is offered.
  task automatic send_byte(bit st, logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.start_req <= st;
    req.byte_req  <= b;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  // Send the buffered line; only its first byte may carry the start flag.
  task automatic send_line(bit st);
    foreach (line_q[i]) send_byte((i == 0) ? st : 1'b0, line_q[i]);
    line_q.delete();
  endtask

  function automatic void add_str(string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endfunction

  // Hex digit with a random letter case.
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_esc(logic [7:0] v);
    line_q.push_back(CH_PCT);
    line_q.push_back(hex_digit(v[7:4]));
    line_q.push_back(hex_digit(v[3:0]));
  endfunction

  // A literal that neither ends the line nor switches state: path bytes avoid
  // '?', query bytes avoid the argument separators.
  function automatic logic [7:0] plain_byte(bit query_side);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == CH_SPACE || c == CH_PCT ||
               (!query_side && c == CH_QMARK) ||
               (query_side && (c == CH_AMP || c == CH_EQ)));
    return c;
  endfunction

  function automatic void add_text(bit query_side, int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) add_esc(8'($urandom_range(0, 255)));
      else line_q.push_back(plain_byte(query_side));
    end
  endfunction

  // Fill the path or the query past its store so the parse ends truncated.
  task automatic long_line(bit query_side);
    add_str("GET /");
    if (query_side) line_q.push_back(CH_QMARK);
    repeat (((URI_BYTES > QUERY_BYTES) ? URI_BYTES : QUERY_BYTES) + 8)
      line_q.push_back(plain_byte(query_side));
    line_q.push_back(CH_NUL);
    send_line(1'b1);
  endtask

  // One random line: mostly well formed with random content, some broken
  // escapes, some raw noise with random start flags.
  task automatic random_line();
    int unsigned mode;
    int unsigned nargs;
    logic [7:0]  bad_tab[9];
    mode    = $urandom_range(0, 99);
    bad_tab = '{CH_NUL, CH_SPACE, 8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'hff};
    if (mode < 8) begin
      repeat ($urandom_range(1, 16))
        send_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      return;
    end
    // method, then the single space
    repeat ($urandom_range(0, 4)) line_q.push_back(plain_byte(1'b0));
    line_q.push_back(CH_SPACE);
    add_text(1'b0, $urandom_range(0, 8));
    if ($urandom_range(0, 4) != 0) begin
      line_q.push_back(CH_QMARK);
      nargs = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_ARGS - 2, MAX_ARGS + 1)
                                          : $urandom_range(0, 4);
      for (int unsigned a = 0; a < nargs; a++) begin
        if (a > 0) line_q.push_back(CH_AMP);
        add_text(1'b1, $urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0) line_q.push_back(CH_QMARK);
        if ($urandom_range(0, 2) != 0) begin
          line_q.push_back(CH_EQ);
          add_text(1'b1, $urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) line_q.push_back(CH_EQ);
        end
      end
    end
    if (mode < 16) begin
      // broken escape: missing first or second hex digit
      line_q.push_back(CH_PCT);
      if ($urandom_range(0, 1)) line_q.push_back(hex_digit(4'($urandom_range(0, 15))));
      line_q.push_back(bad_tab[$urandom_range(0, 8)]);
    end else begin
      line_q.push_back($urandom_range(0, 1) ? CH_NUL : CH_SPACE);
    end
    // trailing bytes after the end of the line are dropped by the parser
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    send_line($urandom_range(0, 19) != 0);
  endtask

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.start_req = 1'b0;
    req.byte_req  = 8'd0;
    res.ready     = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    sent          = 0;
    quiet_cycles  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines. First: no start flag after reset, top byte value in the path.
    add_str("G /");
    line_q.push_back(8'hff);
    line_q.push_back(CH_NUL);
    send_line(1'b0);
    // Line that ends inside the method, then a stray byte that must be dropped.
    line_q.push_back(CH_NUL);
    send_line(1'b1);
    add_str("x");
    send_line(1'b0);
    // Escaped zero, '&', '=' and '?' stay data; later '?' is data; '=' on an
    // empty name; empty argument at '&'; space ends the line.
    add_str("P ?");
    add_esc(8'h00);
    add_esc(CH_AMP);
    add_esc(CH_EQ);
    add_esc(CH_QMARK);
    add_str("=?&=v ");
    send_line(1'b1);
    // Bad second digit, then a zero where the first digit belongs.
    add_str("G %4g");
    send_line(1'b1);
    add_str("G ?a%");
    line_q.push_back(CH_NUL);
    send_line(1'b1);

    // Random phases with different idle and stall pressure.
    for (int p = 0; p < 4; p++) begin
      int unsigned phase_end;
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      if (p == 0) long_line(1'b0);
      if (p == 1) long_line(1'b1);
      phase_end = sent + ITEMS_PER_PHASE;
      while (sent < phase_end) random_line();
    end
    req.valid <= 1'b0;

    // Drain: wait for every predicted result, then wait on for strays.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/hrlp_pkg.sv
rtl/core/hrlp_if.sv
rtl/core/hrlp_front.sv
rtl/core/hrlp_queue.sv
rtl/core/hrlp_back.sv
rtl/core/http_request_line_parser.sv
tb/sv/hrlp_result_checker.sv
tb/sv/tb_http_request_line_parser.sv
